// ----- src/hlc_pkg.sv -----
package hlc_pkg;

  localparam logic [31:0] HashMult = 32'd2654435761;

  typedef struct packed {
    logic [15:0] sh;
    logic [31:0] fh;
    logic [15:0] len;
    logic [15:0] val;
  } entry_t;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic   cmp;      // latch match flag against the probe
    logic   upd;      // apply shift and insert
  } cell_cmd_t;

endpackage

// ----- src/hashed_lru_cache_midpoint_insert.sv -----
// Each input beat passes through the hash, compare, pick and update, and result
// states in turn. The sequencer works one item at a time through the cell chain:
// a new lookup is taken only in idle, after the last result has been taken, so a
// stalled result also holds off the next lookup.
// Reset: asynchronous active low clears count, counters and control; entry
// cells are left undefined and are never read past the entry count.
module hashed_lru_cache_midpoint_insert #(
  parameter int unsigned ENTRIES      = 255,
  parameter int unsigned INSERT_POINT = 223,
  parameter int unsigned MOVE_STEP    = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] key_word_i,
  input  logic [15:0] key_length_i,
  input  logic [31:0] full_hash_i,
  input  logic [15:0] value_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        hit_o,
  output logic [15:0] value_out_o,
  output logic [31:0] hit_count_o,
  output logic [31:0] miss_count_o
);

  // The index width also covers the move step so that a step longer than the
  // list never wraps.
  localparam int unsigned IdxW = $clog2(((MOVE_STEP > ENTRIES) ? MOVE_STEP : ENTRIES) + 1);
  localparam int unsigned IpC  = (INSERT_POINT < ENTRIES) ? INSERT_POINT : ENTRIES - 1;
  localparam logic [IdxW-1:0] Ip    = IdxW'(IpC);
  localparam logic [IdxW-1:0] Step  = IdxW'(MOVE_STEP);
  localparam logic [IdxW-1:0] Full  = IdxW'(ENTRIES);

  typedef enum logic [2:0] {SIdle, SHash, SCmp, SPick, SOut} state_e;
  state_e state_q;

  logic [31:0] key_q, mix;
  hlc_pkg::entry_t probe_q, probe;
  logic [IdxW-1:0] count_q;
  logic [31:0] hits_q, miss_q;
  logic hit_q;
  logic [15:0] vout_q;

  hlc_pkg::entry_t ents [ENTRIES];
  logic [ENTRIES-1:0] match;
  hlc_pkg::cell_cmd_t cmd;

  // Short hash: low word of the key product plus the length in the upper half.
  assign mix = key_q * hlc_pkg::HashMult + {probe_q.len, 16'h0};

  // Priority pick of the front-most matching cell, done combinationally from
  // registered match flags.
  logic            any;
  logic [IdxW-1:0] first;
  always_comb begin
    any   = 1'b0;
    first = '0;
    for (int k = ENTRIES - 1; k >= 0; k--) begin
      if (match[k]) begin
        any   = 1'b1;
        first = IdxW'(k);
      end
    end
  end

  assign cmd.cmp      = (state_q == SCmp);
  assign cmd.upd      = (state_q == SPick);

  // On a hit the probe payload carries the stored value.
  always_comb begin
    probe = probe_q;
    if (any) probe.val = ents[first].val;
  end

  // Shift window for the update: lo receives the probe, (lo, hi] shift back.
  logic [IdxW-1:0] lo_d, hi_d;
  logic            do_upd;
  always_comb begin
    do_upd = 1'b1;
    lo_d   = '0;
    hi_d   = '0;
    if (any) begin
      if (first > Step) begin
        lo_d = first - Step;
        hi_d = first;
      end else begin
        do_upd = 1'b0;
      end
    end else if (count_q <= Ip && count_q < Full) begin
      lo_d = count_q;
      hi_d = count_q;
    end else begin
      lo_d = Ip;
      hi_d = (count_q < Full) ? count_q : Full - 1'b1;
    end
  end

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    hlc_pkg::cell_cmd_t c;
    always_comb begin
      c     = cmd;
      c.upd = cmd.upd & do_upd;
    end
    hlc_cell #(.IdxW(IdxW)) u_cell (
      .clk_i, .rst_ni,
      .my_idx_i (IdxW'(g)),
      .cmd_i    (c),
      .probe_i  (probe),
      .count_i  (count_q),
      .lo_i     (lo_d),
      .hi_i     (hi_d),
      .prev_i   (ents[(g == 0) ? 0 : g - 1]),
      .ent_o    (ents[g]),
      .match_o  (match[g])
    );
  end

  assign in_ready_o  = (state_q == SIdle);
  assign out_valid_o = (state_q == SOut);
  assign hit_o        = hit_q;
  assign value_out_o  = vout_q;
  assign hit_count_o  = hits_q;
  assign miss_count_o = miss_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      count_q <= '0;
      hits_q  <= '0;
      miss_q  <= '0;
      key_q   <= '0;
      probe_q <= '0;
      hit_q   <= 1'b0;
      vout_q  <= '0;
    end else begin
      case (state_q)
        SIdle: if (in_valid_i) begin
          key_q       <= key_word_i;
          probe_q.len <= key_length_i;
          probe_q.fh  <= full_hash_i;
          probe_q.val <= value_in_i;
          state_q     <= SHash;
        end
        SHash: begin
          probe_q.sh <= mix[31:16];
          state_q    <= SCmp;
        end
        SCmp: begin
          state_q <= SPick;
        end
        SPick: begin
          hit_q  <= any;
          vout_q <= probe.val;
          if (any) begin
            hits_q <= hits_q + 32'd1;
          end else begin
            miss_q <= miss_q + 32'd1;
            if (count_q < Full) count_q <= count_q + 1'b1;
          end
          state_q <= SOut;
        end
        SOut: if (out_ready_i) state_q <= SIdle;
        default: state_q <= SIdle;
      endcase
    end
  end

endmodule

// ----- src/hlc_cell.sv -----
module hlc_cell #(
  parameter int unsigned IdxW = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [IdxW-1:0]    my_idx_i,
  input  hlc_pkg::cell_cmd_t cmd_i,
  input  hlc_pkg::entry_t    probe_i,
  input  logic [IdxW-1:0]    count_i,
  input  logic [IdxW-1:0]    lo_i,
  input  logic [IdxW-1:0]    hi_i,
  input  hlc_pkg::entry_t    prev_i,
  output hlc_pkg::entry_t    ent_o,
  output logic               match_o
);

  hlc_pkg::entry_t ent_q;
  logic            match_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else begin
      if (cmd_i.cmp) begin
        match_q <= (my_idx_i < count_i) && (ent_q.sh == probe_i.sh) &&
                   (ent_q.len == probe_i.len) && (ent_q.fh == probe_i.fh);
      end
    end
  end

  // Cells in (lo, hi] take the neighbor's entry; cell lo takes the probe.
  always_ff @(posedge clk_i) begin
    if (cmd_i.upd) begin
      if (my_idx_i == lo_i) begin
        ent_q <= probe_i;
      end else if (my_idx_i > lo_i && my_idx_i <= hi_i) begin
        ent_q <= prev_i;
      end
    end
  end

  assign ent_o   = ent_q;
  assign match_o = match_q;

endmodule

// ----- src/hlc_checker.sv -----
module hlc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        hit_o,
  input logic [31:0] hit_count_o,
  input logic [31:0] miss_count_o
);

  // A new result bumps exactly the counter that matches its hit flag.
  a_one_counter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> (hit_o ?
      (hit_count_o == $past(hit_count_o) + 32'd1 && miss_count_o == $past(miss_count_o)) :
      (miss_count_o == $past(miss_count_o) + 32'd1 && hit_count_o == $past(hit_count_o))))
    else $error("counter check");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("ready while result pending");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(hit_o) &&
      $stable(hit_count_o) && $stable(miss_count_o))) else $error("result moved");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> ##3 out_valid_o) else $error("latency");

endmodule

bind hashed_lru_cache_midpoint_insert hlc_checker u_chk (.*);

// ----- tb/tb.sv -----
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // These match the default parameters of the block under test.
  localparam int unsigned Entries     = 255;
  localparam int unsigned InsertPoint = 223;
  localparam int unsigned MoveStep    = 32;

  typedef struct {
    logic [31:0] key;
    logic [15:0] len;
    logic [31:0] fh;
    logic [15:0] val;
  } lookup_t;

  typedef struct {
    logic        hit;
    logic [15:0] value;
    logic [31:0] hits;
    logic [31:0] misses;
  } answer_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] key_word = '0;
  logic [15:0] key_length = '0;
  logic [31:0] full_hash = '0;
  logic [15:0] value_in = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        hit;
  logic [15:0] value_out;
  logic [31:0] hit_count;
  logic [31:0] miss_count;

  // Beats waiting to be sent, answers waiting to come back, and every key sent so far,
  // which random lookups draw from so that many of them hit.
  lookup_t pending_lookups[$];
  answer_t expected_answers[$];
  lookup_t sent_keys[$];
  int      idle_pct = 0;
  int      stall_pct = 0;
  int      errors = 0;

  // Shadow copy of the cache, kept in list order from the front.
  hlc_pkg::entry_t shadow_list[Entries];
  int unsigned shadow_count = 0;
  logic [31:0] shadow_hits = '0;
  logic [31:0] shadow_misses = '0;

  always #5 clk_i = ~clk_i;

  hashed_lru_cache_midpoint_insert DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .key_word_i  (key_word),
    .key_length_i(key_length),
    .full_hash_i (full_hash),
    .value_in_i  (value_in),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .hit_o       (hit),
    .value_out_o (value_out),
    .hit_count_o (hit_count),
    .miss_count_o(miss_count)
  );

  // Moves entries pos..pos+n-1 back by one place.
  function automatic void shift_entries_back(int unsigned pos, int unsigned n);
    for (int j = pos + n; j > int'(pos); j--) begin
      shadow_list[j] = shadow_list[j-1];
    end
  endfunction

  // Looks up one key in the shadow list, applies the reordering and returns the answer.
  function automatic answer_t cache_lookup(lookup_t lk);
    logic [31:0] mixed;
    hlc_pkg::entry_t e;
    int unsigned pos;
    int unsigned ip;
    answer_t     a;
    mixed = lk.key * hlc_pkg::HashMult + {lk.len, 16'h0000};
    e.sh = mixed[31:16];
    e.fh = lk.fh;
    e.len = lk.len;
    e.val = lk.val;
    ip = (InsertPoint < Entries) ? InsertPoint : Entries - 1;
    pos = 0;
    while (pos < shadow_count && !(shadow_list[pos].sh == e.sh &&
           shadow_list[pos].len == e.len && shadow_list[pos].fh == e.fh)) begin
      pos++;
    end
    if (pos < shadow_count) begin
      // A hit far from the front jumps forward by a fixed step.
      e.val = shadow_list[pos].val;
      shadow_hits++;
      if (pos > MoveStep) begin
        shift_entries_back(pos - MoveStep, MoveStep);
        shadow_list[pos - MoveStep] = e;
      end
      a.hit = 1'b1;
    end else begin
      // A miss appends while the list is short, else lands at the insert point and
      // pushes the tail back, dropping the last entry once the list is full.
      shadow_misses++;
      if (shadow_count <= ip && shadow_count < Entries) begin
        shadow_list[shadow_count] = e;
        shadow_count++;
      end else begin
        if (shadow_count < Entries) shadow_count++;
        shift_entries_back(ip, shadow_count - 1 - ip);
        shadow_list[ip] = e;
      end
      a.hit = 1'b0;
    end
    a.value = e.val;
    a.hits = shadow_hits;
    a.misses = shadow_misses;
    return a;
  endfunction

  // About half are earlier keys, some changed into near misses; the rest are fresh keys.
  function automatic lookup_t random_lookup();
    lookup_t lk;
    int      roll;
    int      n;
    roll = $urandom_range(99);
    n = sent_keys.size();
    if (n > 0 && roll < 50) begin
      lk = sent_keys[$urandom_range(n - 1, (n > 300) ? n - 300 : 0)];
      lk.val = 16'($urandom);
      if (roll < 8) lk.fh[$urandom_range(31)] ^= 1'b1;
      else if (roll < 12) lk.len = 16'($urandom);
      else if (roll < 15) lk.key = $urandom;
    end else begin
      lk.key = $urandom;
      lk.len = (roll < 80) ? 16'($urandom_range(64)) : 16'($urandom);
      lk.fh = $urandom;
      lk.val = 16'($urandom);
    end
    return lk;
  endfunction

  function automatic lookup_t make_lookup(logic [31:0] k, logic [15:0] l,
                                          logic [31:0] f, logic [15:0] v);
    lookup_t lk;
    lk.key = k;
    lk.len = l;
    lk.fh = f;
    lk.val = v;
    return lk;
  endfunction

  // Driver: predicts on each accepted beat, then offers the next lookup unless idling.
  always @(posedge clk_i or negedge rst_ni) begin
    lookup_t nxt;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_answers.push_back(cache_lookup(
            make_lookup(key_word, key_length, full_hash, value_in)));
      end
      if (!in_valid || in_ready) begin
        if (pending_lookups.size() > 0 && $urandom_range(99) >= idle_pct) begin
          nxt = pending_lookups.pop_front();
          sent_keys.push_back(nxt);
          in_valid <= 1'b1;
          key_word <= nxt.key;
          key_length <= nxt.len;
          full_hash <= nxt.fh;
          value_in <= nxt.val;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Monitor: every result beat is checked against the oldest prediction.
  always @(posedge clk_i) begin
    answer_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (expected_answers.size() == 0) begin
        $display("%0t: result beat with nothing expected (hit %0b value %h)",
                 $realtime, hit, value_out);
        errors++;
      end else begin
        want = expected_answers.pop_front();
        if (hit !== want.hit) begin
          $display("%0t: hit expected %0b actual %0b", $realtime, want.hit, hit);
          errors++;
        end
        if (value_out !== want.value) begin
          $display("%0t: value_out expected %h actual %h", $realtime, want.value, value_out);
          errors++;
        end
        if (hit_count !== want.hits) begin
          $display("%0t: hit_count expected %0d actual %0d", $realtime, want.hits, hit_count);
          errors++;
        end
        if (miss_count !== want.misses) begin
          $display("%0t: miss_count expected %0d actual %0d", $realtime, want.misses,
                   miss_count);
          errors++;
        end
      end
    end
  end

  task automatic drain();
    while (pending_lookups.size() > 0 || expected_answers.size() > 0 || in_valid) begin
      @(posedge clk_i);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: field extremes, exact repeats for hits, and near misses that differ in
    // only the full hash or the length.
    pending_lookups.push_back(make_lookup('0, '0, '0, '0));
    pending_lookups.push_back(make_lookup('1, '1, '1, '1));
    pending_lookups.push_back(make_lookup('0, '0, '0, 16'h1234));
    pending_lookups.push_back(make_lookup('1, '1, '1, 16'h0000));
    pending_lookups.push_back(make_lookup('1, '1, 32'hFFFF_FFFE, 16'h5555));
    pending_lookups.push_back(make_lookup('1, 16'hFFFE, '1, 16'hAAAA));
    pending_lookups.push_back(make_lookup(32'h8000_0000, 16'h8000, 32'h8000_0000, 16'h8000));
    pending_lookups.push_back(make_lookup(32'h0000_0001, 16'h0001, 32'h0000_0001, 16'h0001));
    pending_lookups.push_back(make_lookup(32'h8000_0000, 16'h8000, 32'h8000_0000, 16'h0));
    // Two key words with the same full hash and length zero but different short hashes: both miss.
    pending_lookups.push_back(make_lookup(32'h0000_0000, 16'h0000, 32'hCAFE_0000, 16'h0101));
    pending_lookups.push_back(make_lookup(32'h0001_0000, 16'h0000, 32'hCAFE_0000, 16'h0202));
    idle_pct = 0;
    stall_pct = 0;
    drain();

    // Random phases; the sender also waits for every answer between phases.
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 84 : 13) : 0;
      stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 84 : 13) : 0;
      for (int i = 0; i < 140; i++) pending_lookups.push_back(random_lookup());
      drain();
    end

    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("Some tests failed");
    $finish;
  end

endmodule
